>>> rtl/core/lsp_pkg.sv
// Shared constants, types and codes of the looping sample player.
package lsp_pkg;

  localparam int unsigned FRAMES      = 65536;
  localparam int unsigned ADDR_W      = $clog2(FRAMES);
  localparam int unsigned BANK_AW     = ADDR_W - 1;
  localparam int unsigned BANK_DEPTH  = FRAMES / 2;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned POS_BITS    = 34;
  localparam int unsigned LEN_W       = 17;
  localparam int unsigned START_W     = 32;
  localparam int unsigned END_W       = 16;
  localparam int unsigned STEP_W      = 20;
  localparam int unsigned SEEK_W      = 32;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned PROD_W      = 2 * (SAMPLE_BITS + 1);

  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FRAMES);

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_RENDER = 2'd1,
    MODE_SEEK   = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH  = 3'd0,
    CFG_START   = 3'd1,
    CFG_END     = 3'd2,
    CFG_LOOPING = 3'd3,
    CFG_STEP    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
  } frame_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    frame_t            data;
  } wr_req_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] even_addr;
    logic [BANK_AW-1:0] odd_addr;
  } rd_req_t;

  typedef struct packed {
    logic                 valid;
    logic                 play;
    logic                 base_odd;
    logic                 next_odd;
    logic [FRAC_BITS-1:0] frac;
  } interp_req_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          playing;
  } result_t;

endpackage

>>> rtl/core/lsp_if.sv
// Channel interfaces: command input, result output, configuration write.
interface lsp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [1:0]                            mode;
  logic [lsp_pkg::ADDR_W-1:0]            frame_address;
  logic signed [lsp_pkg::SAMPLE_BITS-1:0] left_in;
  logic signed [lsp_pkg::SAMPLE_BITS-1:0] right_in;
  logic [lsp_pkg::SEEK_W-1:0]            seek_position;

  modport source (output valid, mode, frame_address, left_in, right_in, seek_position,
                  input ready);
  modport sink   (input valid, mode, frame_address, left_in, right_in, seek_position,
                  output ready);
endinterface

interface lsp_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [lsp_pkg::SAMPLE_BITS-1:0] left_out;
  logic signed [lsp_pkg::SAMPLE_BITS-1:0] right_out;
  logic                                  playing;

  modport source (output valid, left_out, right_out, playing, input ready);
  modport sink   (input valid, left_out, right_out, playing, output ready);
endinterface

interface lsp_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [lsp_pkg::CFG_IDX_W-1:0]    index;
  logic [lsp_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/lsp_store.sv
// Stereo sample store split into even and odd frame banks.
module lsp_store (
  input  logic             clk_i,
  input  lsp_pkg::wr_req_t wr_i,
  input  lsp_pkg::rd_req_t rd_i,
  output lsp_pkg::frame_t  even_o,
  output lsp_pkg::frame_t  odd_o
);

  lsp_pkg::frame_t mem_even [lsp_pkg::BANK_DEPTH];
  lsp_pkg::frame_t mem_odd  [lsp_pkg::BANK_DEPTH];
  lsp_pkg::frame_t even_q;
  lsp_pkg::frame_t odd_q;

  // bank select by address lsb
  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.addr[0]) begin
      mem_even[wr_i.addr[lsp_pkg::ADDR_W-1:1]] <= wr_i.data;
    end
    if (wr_i.en && wr_i.addr[0]) begin
      mem_odd[wr_i.addr[lsp_pkg::ADDR_W-1:1]] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      even_q <= mem_even[rd_i.even_addr];
      odd_q  <= mem_odd[rd_i.odd_addr];
    end
  end

  assign even_o = even_q;
  assign odd_o  = odd_q;

endmodule

>>> rtl/core/lsp_interp.sv
// Two-stage stereo linear interpolator: multiply, then round and add.
module lsp_interp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lsp_pkg::interp_req_t req_i,
  input  lsp_pkg::frame_t      even_i,
  input  lsp_pkg::frame_t      odd_i,
  output logic                 res_valid_o,
  output lsp_pkg::result_t     res_o
);

  localparam int unsigned SW = lsp_pkg::SAMPLE_BITS;
  localparam int unsigned PW = lsp_pkg::PROD_W;
  localparam logic signed [PW-1:0] HALF = PW'(1) <<< (lsp_pkg::FRAC_BITS - 1);

  lsp_pkg::frame_t         base_w, next_w;
  logic signed [SW:0]      frac_s;
  logic signed [SW:0]      dl, dr;
  logic signed [PW-1:0]    prod_l_d, prod_r_d;
  logic signed [PW-1:0]    prod_l_q, prod_r_q;
  logic signed [SW-1:0]    a_l_q, a_r_q;
  logic                    s3_valid_q, s3_play_q;
  logic signed [PW-1:0]    rnd_l, rnd_r;

  always_comb begin
    base_w   = req_i.base_odd ? odd_i : even_i;
    next_w   = req_i.next_odd ? odd_i : even_i;
    frac_s   = $signed({1'b0, req_i.frac});
    dl       = $signed({next_w.left[SW-1], next_w.left})
             - $signed({base_w.left[SW-1], base_w.left});
    dr       = $signed({next_w.right[SW-1], next_w.right})
             - $signed({base_w.right[SW-1], base_w.right});
    prod_l_d = PW'(dl * frac_s);
    prod_r_d = PW'(dr * frac_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid) begin
      prod_l_q  <= prod_l_d;
      prod_r_q  <= prod_r_d;
      a_l_q     <= base_w.left;
      a_r_q     <= base_w.right;
      s3_play_q <= req_i.play;
    end
  end

  // round half up, arithmetic floor on the scaled product
  always_comb begin
    rnd_l = (prod_l_q + HALF) >>> lsp_pkg::FRAC_BITS;
    rnd_r = (prod_r_q + HALF) >>> lsp_pkg::FRAC_BITS;
    res_o.playing = s3_play_q;
    res_o.left    = s3_play_q ? SW'(a_l_q + rnd_l[SW-1:0]) : '0;
    res_o.right   = s3_play_q ? SW'(a_r_q + rnd_r[SW-1:0]) : '0;
  end

  assign res_valid_o = s3_valid_q;

endmodule

>>> rtl/core/lsp_out_fifo.sv
// Small result queue between the interpolator and the output channel.
module lsp_out_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  lsp_pkg::result_t                  data_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output lsp_pkg::result_t                  data_o,
  output logic [lsp_pkg::FIFO_CNT_W-1:0]    cnt_o
);

  lsp_pkg::result_t                  slot_q [lsp_pkg::FIFO_DEPTH];
  logic [lsp_pkg::FIFO_PTR_W-1:0]    head_q, tail_q;
  logic [lsp_pkg::FIFO_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        tail_q <= tail_q + 1'b1;
      end
      if (do_pop) begin
        head_q <= head_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[tail_q] <= data_i;
    end
  end

  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[head_q];
  assign cnt_o   = cnt_q;

endmodule

>>> rtl/core/looping_sample_player_interp.sv
// Looping stereo sample player with linear interpolation, top level.
//
// One transaction on in_i is a load (writes one stereo frame into the sample
// store), a seek (sets the 16.16 read position, clamped to the used length,
// and restarts playback) or a render (returns one interpolated stereo frame
// on out_o, then advances the position by step, wrapping or stopping at the
// end). Loads and seeks are taken every cycle while in_i.ready is high; a
// render holds in_i.ready low for the following cycle, so a new render is
// not taken before the read position update of the last one: the end compare
// is made in the accept cycle, and the wrap and the stepped position are
// written back in the next cycle. Render path: end check in the accept
// cycle, store read (both frames at once from the even and odd banks),
// multiply, then round and add into the output queue. A 4-entry output
// queue decouples the output side; in_i.ready also drops when the queue
// plus renders in flight would exceed it. After a configuration write
// in_i.ready is low for one cycle while derived limits settle.
// Configuration must be written only while idle; the block does not enforce
// it. Store entries that were never loaded read as undefined values.
module looping_sample_player_interp (
  input  logic      clk_i,
  input  logic      rst_ni,
  lsp_cfg_if.sink   cfg_i,
  lsp_in_if.sink    in_i,
  lsp_out_if.source out_o
);

  localparam int unsigned FB = lsp_pkg::FRAC_BITS;
  localparam int unsigned PB = lsp_pkg::POS_BITS;
  localparam int unsigned AW = lsp_pkg::ADDR_W;
  localparam int unsigned LW = lsp_pkg::LEN_W;

  // configuration registers
  logic [LW-1:0]                   length_q;
  logic [lsp_pkg::START_W-1:0]     start_q;
  logic [lsp_pkg::END_W-1:0]       end_q;
  logic                            looping_q;
  logic [lsp_pkg::STEP_W-1:0]      step_q;
  logic                            cfg_wr_q;

  // derived limits, refreshed every cycle from the registers above
  logic [LW-1:0]                   len_eff;
  logic [AW-1:0]                   len_m1_d, len_m1_q;
  logic [AW-1:0]                   end_frame;
  logic [AW+FB-1:0]                end_fx_d, end_fx_q;
  logic [LW+FB-1:0]                lim_d, lim_q;
  logic [lsp_pkg::START_W:0]       start_step_d, start_step_q;

  // player state
  logic [PB-1:0]                   pos_q;
  logic                            play_q;

  // render stage 1: end check result
  logic                            r1_valid_q;
  logic                            r1_hit_q;
  logic [PB-1:0]                   r1_diff_q;

  // stage 1 combinational path
  logic                            wrap, stop, play_n;
  logic [PB-1:0]                   pos_w;
  logic [PB-FB-1:0]                base_full;
  logic [AW-1:0]                   base, next;
  logic [AW-1:0]                   even_sel, odd_sel;

  lsp_pkg::interp_req_t            r2_q;
  lsp_pkg::wr_req_t                wr_req;
  lsp_pkg::rd_req_t                rd_req;
  lsp_pkg::frame_t                 even_rd, odd_rd;
  lsp_pkg::result_t                res, fifo_data;
  logic                            res_valid;
  logic [lsp_pkg::FIFO_CNT_W-1:0]  fifo_cnt;
  logic [lsp_pkg::FIFO_CNT_W-1:0]  credit_used;
  logic                            fifo_valid;

  logic                            in_acc, load_acc, render_acc, seek_acc, cfg_acc;
  logic [lsp_pkg::SEEK_W:0]        seek_clamped;

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      length_q  <= lsp_pkg::LEN_MAX;
      start_q   <= '0;
      end_q     <= '1;
      looping_q <= 1'b0;
      step_q    <= lsp_pkg::STEP_W'(1) << FB;
      cfg_wr_q  <= 1'b0;
    end else begin
      cfg_wr_q <= cfg_acc;
      if (cfg_acc) begin
        case (lsp_pkg::cfg_idx_e'(cfg_i.index))
          lsp_pkg::CFG_LENGTH:  length_q  <= cfg_i.data[LW-1:0];
          lsp_pkg::CFG_START:   start_q   <= cfg_i.data[lsp_pkg::START_W-1:0];
          lsp_pkg::CFG_END:     end_q     <= cfg_i.data[lsp_pkg::END_W-1:0];
          lsp_pkg::CFG_LOOPING: looping_q <= cfg_i.data[0];
          lsp_pkg::CFG_STEP:    step_q    <= cfg_i.data[lsp_pkg::STEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Effective length clamps to 2..FRAMES; an end at or past it means len-1.
  always_comb begin
    len_eff = length_q;
    if (length_q < lsp_pkg::LEN_MIN) begin
      len_eff = lsp_pkg::LEN_MIN;
    end else if (length_q > lsp_pkg::LEN_MAX) begin
      len_eff = lsp_pkg::LEN_MAX;
    end
    len_m1_d     = AW'(len_eff - 1'b1);
    end_frame    = ({1'b0, end_q} >= len_eff) ? len_m1_d : end_q;
    end_fx_d     = {end_frame, {FB{1'b0}}};
    lim_d        = {len_eff, {FB{1'b0}}};
    start_step_d = {1'b0, start_q} + (lsp_pkg::START_W + 1)'(step_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_m1_q     <= '1;
      end_fx_q     <= {{AW{1'b1}}, {FB{1'b0}}};
      lim_q        <= {lsp_pkg::LEN_MAX, {FB{1'b0}}};
      start_step_q <= (lsp_pkg::START_W + 1)'(1) << FB;
    end else begin
      len_m1_q     <= len_m1_d;
      end_fx_q     <= end_fx_d;
      lim_q        <= lim_d;
      start_step_q <= start_step_d;
    end
  end

  // ---------------------------------------------------------------------
  // Input acceptance
  // ---------------------------------------------------------------------
  assign credit_used = fifo_cnt + lsp_pkg::FIFO_CNT_W'(r2_q.valid)
                     + lsp_pkg::FIFO_CNT_W'(res_valid);
  assign in_i.ready  = !r1_valid_q && !cfg_wr_q
                     && (credit_used < lsp_pkg::FIFO_CNT_W'(lsp_pkg::FIFO_DEPTH));
  assign in_acc      = in_i.valid && in_i.ready;

  always_comb begin
    load_acc   = 1'b0;
    render_acc = 1'b0;
    seek_acc   = 1'b0;
    if (in_acc) begin
      case (lsp_pkg::mode_e'(in_i.mode))
        lsp_pkg::MODE_LOAD:   load_acc   = 1'b1;
        lsp_pkg::MODE_RENDER: render_acc = 1'b1;
        lsp_pkg::MODE_SEEK:   seek_acc   = 1'b1;
        default: ;
      endcase
    end
  end

  assign seek_clamped = ({1'b0, in_i.seek_position} > lim_q)
                      ? lim_q : {1'b0, in_i.seek_position};

  // loads go straight into the store; the one-cycle render bubble keeps a
  // load from landing in the cycle the store is read
  always_comb begin
    wr_req.en         = load_acc;
    wr_req.addr       = in_i.frame_address;
    wr_req.data.left  = in_i.left_in;
    wr_req.data.right = in_i.right_in;
  end

  // ---------------------------------------------------------------------
  // Render stage 1: apply wrap or stop, read both frames, step position
  // ---------------------------------------------------------------------
  always_comb begin
    wrap      = r1_hit_q && looping_q;
    stop      = r1_hit_q && !looping_q;
    play_n    = play_q && !stop;
    pos_w     = wrap ? (r1_diff_q + PB'(start_q)) : pos_q;
    base_full = pos_w[PB-1:FB];
    // base saturates at len-1; next equals base there
    base      = (base_full > (PB-FB)'(len_m1_q)) ? len_m1_q : base_full[AW-1:0];
    next      = (base == len_m1_q) ? base : base + 1'b1;
    even_sel  = base[0] ? next : base;
    odd_sel   = base[0] ? base : next;

    rd_req.en        = r1_valid_q;
    rd_req.even_addr = even_sel[AW-1:1];
    rd_req.odd_addr  = odd_sel[AW-1:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      play_q     <= 1'b1;
      r1_valid_q <= 1'b0;
      r2_q       <= '0;
    end else begin
      r1_valid_q <= render_acc;
      r2_q.valid <= r1_valid_q;
      if (seek_acc) begin
        pos_q  <= PB'(seek_clamped);
        play_q <= 1'b1;
      end
      if (r1_valid_q) begin
        play_q        <= play_n;
        r2_q.play     <= play_n;
        r2_q.base_odd <= base[0];
        r2_q.next_odd <= next[0];
        r2_q.frac     <= pos_w[FB-1:0];
        if (play_n) begin
          pos_q <= wrap ? (r1_diff_q + PB'(start_step_q)) : (pos_q + PB'(step_q));
        end
      end
    end
  end

  // accept cycle: end compare against the current position
  always_ff @(posedge clk_i) begin
    if (render_acc) begin
      r1_hit_q  <= play_q && (pos_q >= PB'(end_fx_q));
      r1_diff_q <= pos_q - PB'(end_fx_q);
    end
  end

  // ---------------------------------------------------------------------
  // Store, interpolator, output queue
  // ---------------------------------------------------------------------
  lsp_store u_store (
    .clk_i  (clk_i),
    .wr_i   (wr_req),
    .rd_i   (rd_req),
    .even_o (even_rd),
    .odd_o  (odd_rd)
  );

  lsp_interp u_interp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (r2_q),
    .even_i      (even_rd),
    .odd_i       (odd_rd),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lsp_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .pop_i   (out_o.ready),
    .valid_o (fifo_valid),
    .data_o  (fifo_data),
    .cnt_o   (fifo_cnt)
  );

  assign out_o.valid     = fifo_valid;
  assign out_o.left_out  = fifo_data.left;
  assign out_o.right_out = fifo_data.right;
  assign out_o.playing   = fifo_data.playing;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // queue plus renders in flight never exceed the queue depth
  a_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    credit_used <= lsp_pkg::FIFO_CNT_W'(lsp_pkg::FIFO_DEPTH))
    else $error("output queue credit overrun");

  // a stopped result carries silence
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.playing) |-> (out_o.left_out == '0 && out_o.right_out == '0))
    else $error("stopped result not silent");

  // a non-looping end hit leaves the position and clears playing
  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r1_valid_q && r1_hit_q && !looping_q) |=> ($stable(pos_q) && !play_q))
    else $error("stop changed position or kept playing");

  // each accepted render reaches the interpolator output
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    render_acc |-> ##3 res_valid)
    else $error("render lost in pipeline");

endmodule
